>>> hw/rtl/bvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint value table package
// Sizes, command and status codes and the table entry type used by the core,
// which also sizes its storage with them.
// ----------------------------------------------------------------------------
package bvt_pkg;

    // Table size and derived widths
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths
    localparam int CLOCK_W     = 31;
    localparam int VALUE_W     = 16;
    localparam int COUNT_OUT_W = 9;
    localparam int STATUS_W    = 3;

    // Command codes
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED     = 3'd0,
        ST_UPDATED      = 3'd1,
        ST_FULL         = 3'd2,
        ST_READ_HIT     = 3'd3,
        ST_READ_DEFAULT = 3'd4
    } t_status;

    // One breakpoint as stored in the table memory
    typedef struct packed {
        logic [CLOCK_W-1:0]        clock;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

>>> hw/rtl/bvt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint table RAM
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module bvt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/breakpoint_value_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint value table core
// Sorted table of (clock, value) breakpoints with set (update or insert) and
// floor-lookup read requests.
// ----------------------------------------------------------------------------
// Each request makes one forward pass over the points held in the table RAM,
// one entry per cycle through its single read port; an update or a read
// stops as soon as it reaches the matching or following point. An insert
// shifts the later points up in the same pass: each entry read is written
// back one place higher, so no separate shift pass is needed. One request
// is in flight at a time; the next is accepted while the previous result
// still waits in the output register. Set requests at a new clock are
// dropped with status full when the table holds TABLE_DEPTH points. The
// default value register is written through the cfg port and is returned
// by reads of an empty table.
// ----------------------------------------------------------------------------
module breakpoint_value_table_core
    import bvt_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic signed [VALUE_W-1:0] i_cfg_data,
    // request channel
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_command,
    input  wire logic [CLOCK_W-1:0]        i_clock_pos,
    input  wire logic signed [VALUE_W-1:0] i_new_value,
    // result channel
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic signed [VALUE_W-1:0]      o_read_value,
    output logic [STATUS_W-1:0]            o_status,
    output logic [COUNT_OUT_W-1:0]         o_point_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic                       r_cmd;
    logic [CLOCK_W-1:0]         r_pos;
    logic signed [VALUE_W-1:0]  r_val;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_next;
    logic                       r_dv;
    logic [ADDR_W-1:0]          r_didx;
    logic                       r_shift;
    t_entry                     r_carry;
    logic signed [VALUE_W-1:0]  r_last;
    logic                       r_any;
    logic signed [VALUE_W-1:0]  r_res_value;
    t_status                    r_res_status;
    logic                       r_ovalid;
    logic signed [VALUE_W-1:0]  r_o_value;
    t_status                    r_o_status;
    logic [COUNT_OUT_W-1:0]     r_o_count;
    logic signed [VALUE_W-1:0]  r_default;

    logic                       in_acc;
    logic                       out_free;
    logic                       full;
    logic [ENTRY_W-1:0]         ram_rdata;
    t_entry                     rd_entry;
    t_entry                     new_entry;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    t_entry                     mem_wdata;
    logic                       ev_done;
    logic                       ev_insert;
    logic                       ev_shift_start;
    logic                       ev_last;
    logic signed [VALUE_W-1:0]  ev_value;
    t_status                    ev_status;
    logic [31:0]                count_wide;

    // Table storage
    bvt_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_next[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_entry        = t_entry'(ram_rdata);
    assign new_entry.clock = r_pos;
    assign new_entry.value = r_val;
    assign full            = (r_count == CNT_W'(TABLE_DEPTH));

    // Handshakes
    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_ovalid || !i_stall;
    assign o_cfg_ready = 1'b1;

    // Scan decisions: compare the entry returned by the RAM and write back
    always_comb begin
        mem_we         = 1'b0;
        mem_waddr      = r_didx;
        mem_wdata      = r_carry;
        ev_done        = 1'b0;
        ev_insert      = 1'b0;
        ev_shift_start = 1'b0;
        ev_last        = 1'b0;
        ev_value       = '0;
        ev_status      = ST_INSERTED;
        if (r_state == S_SCAN) begin
            if (r_dv) begin
                priority if (r_shift) begin
                    // move the carried entry one place up
                    mem_we = 1'b1;
                end else if (rd_entry.clock < r_pos) begin
                    ev_last = 1'b1;
                end else if (rd_entry.clock == r_pos) begin
                    ev_done = 1'b1;
                    if (r_cmd == CMD_SET) begin
                        mem_we    = 1'b1;
                        mem_wdata = new_entry;
                        ev_status = ST_UPDATED;
                    end else begin
                        ev_value  = rd_entry.value;
                        ev_status = ST_READ_HIT;
                    end
                end else begin
                    // first point past the requested clock
                    priority if (r_cmd == CMD_READ) begin
                        ev_done   = 1'b1;
                        ev_value  = r_any ? r_last : rd_entry.value;
                        ev_status = ST_READ_HIT;
                    end else if (full) begin
                        ev_done   = 1'b1;
                        ev_status = ST_FULL;
                    end else begin
                        mem_we         = 1'b1;
                        mem_wdata      = new_entry;
                        ev_shift_start = 1'b1;
                    end
                end
            end else if (r_next == r_count) begin
                // all points visited
                ev_done   = 1'b1;
                mem_waddr = r_count[ADDR_W-1:0];
                if (r_cmd == CMD_SET) begin
                    priority if (r_shift) begin
                        mem_we    = 1'b1;
                        ev_insert = 1'b1;
                        ev_status = ST_INSERTED;
                    end else if (full) begin
                        ev_status = ST_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = new_entry;
                        ev_insert = 1'b1;
                        ev_status = ST_INSERTED;
                    end
                end else if (r_count == '0) begin
                    ev_value  = r_default;
                    ev_status = ST_READ_DEFAULT;
                end else begin
                    ev_value  = r_last;
                    ev_status = ST_READ_HIT;
                end
            end
        end
    end

    // Point count on the result bus
    assign count_wide = 32'(r_count);

    // Control, scan state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next    <= '0;
            r_dv      <= 1'b0;
            r_shift   <= 1'b0;
            r_any     <= 1'b0;
            r_ovalid  <= 1'b0;
            r_default <= '0;
        end else begin
            // configuration write
            if (i_cfg_valid && o_cfg_ready) begin
                r_default <= i_cfg_data;
            end

            // drop the result once taken, unless a new one replaces it
            if (r_ovalid && !i_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= i_command;
                        r_pos   <= i_clock_pos;
                        r_val   <= i_new_value;
                        r_next  <= '0;
                        r_dv    <= 1'b0;
                        r_shift <= 1'b0;
                        r_any   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // advance the read pointer
                    if (r_next < r_count) begin
                        r_next <= r_next + 1'b1;
                        r_didx <= r_next[ADDR_W-1:0];
                        r_dv   <= 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (ev_last) begin
                        r_last <= rd_entry.value;
                        r_any  <= 1'b1;
                    end
                    if (r_dv && (r_shift || ev_shift_start)) begin
                        r_carry <= rd_entry;
                    end
                    if (ev_shift_start) begin
                        r_shift <= 1'b1;
                    end
                    if (ev_insert) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (ev_done) begin
                        r_res_value  <= ev_value;
                        r_res_status <= ev_status;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_ovalid   <= 1'b1;
                        r_o_value  <= r_res_value;
                        r_o_status <= r_res_status;
                        r_o_count  <= count_wide[COUNT_OUT_W-1:0];
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_read_value  = r_o_value;
    assign o_status      = r_o_status;
    assign o_point_count = r_o_count;

    // The table never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("point count above table depth");

    // The count only grows, by one, at the end of an insert
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + 1'b1) && $past(ev_insert))
        else $error("point count changed without an insert");

    // Set results carry a zero read value
    a_set_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_INSERTED || o_status == ST_UPDATED ||
                    o_status == ST_FULL) |-> (o_read_value == '0))
        else $error("set result with nonzero read value");

    // An accepted request always starts a scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCAN))
        else $error("accepted request did not start a scan");

endmodule
`default_nettype wire
